// ===== rtl/cab_pkg.sv =====
// cab_pkg: shared types, constants and blend helpers for the cropped alpha blit
// no dependencies; imported by every module under rtl/
package cab_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 80;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] SPREAD_MASK = 32'h07E0_F81F;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_BACKGROUND   = 3'd4;
    localparam logic [2:0] CFG_BLEND_ENABLE = 3'd5;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [7:0]  alpha_value;
    } cab_in_t;

    typedef struct packed {
        logic [7:0]  screen_x;
        logic [6:0]  screen_y;
        logic [15:0] out_color;
    } cab_out_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [14:0]        image_width;
        logic [14:0]        image_height;
        logic [15:0]        background_color;
        logic               blend_enable;
    } cab_cfg_t;

    // one on-screen pixel waiting for the back end
    typedef struct packed {
        logic [7:0]  screen_x;
        logic [6:0]  screen_y;
        logic [15:0] pixel_color;
        logic [7:0]  alpha_value;
    } cab_work_t;

    // rgb565 -> green in the upper half, red and blue in the lower half
    function automatic logic [31:0] spread565(input logic [15:0] c);
        return {5'b0, c[10:5], 5'b0, c[15:11], 6'b0, c[4:0]};
    endfunction

    function automatic logic [15:0] pack565(input logic [31:0] t);
        return {t[15:11], t[26:21], t[4:0]};
    endfunction

endpackage

// ===== rtl/cab_front.sv =====
// cab_front: raster counters, screen placement and clipping
// depends on cab_pkg
module cab_front import cab_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cab_cfg_t  cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  cab_in_t   s_data,
    input  logic      q_full,
    output logic      q_push,
    output cab_work_t q_data
);

    logic [14:0]        column_count_reg, column_count_next;
    logic [14:0]        row_count_reg, row_count_next;
    logic [14:0]        col_inc, row_inc;
    logic signed [16:0] sx, sy;
    logic               on_screen, accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign sx = 17'(cfg.origin_x) + $signed({2'b00, column_count_reg});
    assign sy = 17'(cfg.origin_y) + $signed({2'b00, row_count_reg});

    assign on_screen = (sx >= 17'sd0) && (sx < 17'(SCREEN_WIDTH))
                    && (sy >= 17'sd0) && (sy < 17'(SCREEN_HEIGHT));

    assign q_push               = accept && on_screen;
    assign q_data.screen_x      = sx[7:0];
    assign q_data.screen_y      = sy[6:0];
    assign q_data.pixel_color   = s_data.pixel_color;
    assign q_data.alpha_value   = s_data.alpha_value;

    // a size of zero behaves as one; a counter past a shrunk size wraps
    always_comb begin
        col_inc           = column_count_reg + 15'd1;
        row_inc           = row_count_reg + 15'd1;
        column_count_next = col_inc;
        row_count_next    = row_count_reg;
        if (col_inc >= cfg.image_width || col_inc == 15'd0) begin
            column_count_next = '0;
            row_count_next    = row_inc;
            if (row_inc >= cfg.image_height || row_inc == 15'd0) begin
                row_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (accept) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

// ===== rtl/cab_queue.sv =====
// cab_queue: short fifo that decouples pixel classification from blending
// depends on cab_pkg
module cab_queue import cab_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cab_work_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output cab_work_t head_data
);

    cab_work_t         store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) store_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== rtl/cab_back.sv =====
// cab_back: alpha blend in spread rgb565 form and the output register
// depends on cab_pkg
module cab_back import cab_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cab_cfg_t  cfg,
    input  logic      head_valid,
    input  cab_work_t head_data,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output cab_out_t  m_data
);

    logic        m_valid_reg;
    cab_out_t    m_data_reg, m_data_next;
    logic [8:0]  alpha_sum;
    logic [5:0]  alpha_q;
    logic [31:0] fg, bg, diff, prod, blend;

    assign alpha_sum = {1'b0, head_data.alpha_value} + 9'd4;
    assign alpha_q   = alpha_sum[8:3];
    assign fg        = spread565(head_data.pixel_color);
    assign bg        = spread565(cfg.background_color);
    assign diff      = fg - bg;
    assign prod      = diff * {26'b0, alpha_q};
    assign blend     = ({5'b0, prod[31:5]} + bg) & SPREAD_MASK;

    always_comb begin
        m_data_next.screen_x  = head_data.screen_x;
        m_data_next.screen_y  = head_data.screen_y;
        m_data_next.out_color = cfg.blend_enable ? pack565(blend) : head_data.pixel_color;
    end

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/cropped_alpha_blit.sv =====
// cropped_alpha_blit: top level; configuration registers, front, queue and back
// depends on cab_pkg, cab_front, cab_queue, cab_back
//
// Draws an image, streamed in raster order, onto a 160x80 rgb565 screen. Each
// input beat is one image pixel (rgb565 color plus 8-bit alpha); internal
// column/row counters, wrapping at image_width x image_height, place it at
// (origin_x + column, origin_y + row). Pixels that land off screen are dropped
// and give no output beat, but still advance the counters. Each on-screen pixel
// gives one output beat with its screen coordinates and either the raw color
// (blend_enable = 0) or the color blended over background_color with alpha
// rounded to 0..32 (blend_enable = 1). A size register of zero acts as one.
// Throughput is one pixel per clock while s_ready is high: the front end
// classifies a pixel in the cycle it is accepted and pushes it into a
// four-entry queue; the back end blends the queue head (one 32x6 multiply)
// into the output register. An on-screen pixel is written into the queue,
// then moved from its head into the output register, which raises m_valid.
// The queue lets s_ready stay high while a result waits on m_ready; s_ready
// drops only when the queue is full. Configuration writes take effect on the
// next clock and must be made while no pixel is in flight.
module cropped_alpha_blit import cab_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  cab_in_t     s_data,
    // screen write output
    output logic        m_valid,
    input  logic        m_ready,
    output cab_out_t    m_data
);

    cab_cfg_t  cfg_reg;
    logic      q_push, q_full, q_pop, q_head_valid;
    cab_work_t q_push_data, q_head_data;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
            cfg_reg.image_width      <= 15'd1;
            cfg_reg.image_height     <= 15'd1;
            cfg_reg.background_color <= '0;
            cfg_reg.blend_enable     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ORIGIN_X:     cfg_reg.origin_x         <= $signed(cfg_wdata);
                CFG_ORIGIN_Y:     cfg_reg.origin_y         <= $signed(cfg_wdata);
                CFG_IMAGE_WIDTH:  cfg_reg.image_width      <= cfg_wdata[14:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height     <= cfg_wdata[14:0];
                CFG_BACKGROUND:   cfg_reg.background_color <= cfg_wdata;
                CFG_BLEND_ENABLE: cfg_reg.blend_enable     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front end: counters and clipping, pushes on-screen pixels only
    cab_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    // decoupling queue between classification and blending
    cab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // back end: blend and output register
    cab_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== dv/cropped_alpha_blit_tb.sv =====
`timescale 1ns / 1ps
// cropped_alpha_blit_tb: self-checking testbench for the cropped alpha blit
// depends on cab_pkg and the rtl under rtl/; predicts every screen write and checks it
module cropped_alpha_blit_tb;
    import cab_pkg::*;

    // ------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_ORIGIN_X;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    cab_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    cab_out_t    m_data;

    cropped_alpha_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // shadow copy of the blit registers and raster position
    // ------------------------------------------------------------------
    logic signed [15:0] cur_origin_x   = 16'sd0;
    logic signed [15:0] cur_origin_y   = 16'sd0;
    logic [14:0]        cur_width      = 15'd1;
    logic [14:0]        cur_height     = 15'd1;
    logic [15:0]        cur_background = 16'h0000;
    logic               cur_blend      = 1'b0;
    int                 col_pos        = 0;
    int                 row_pos        = 0;

    cab_in_t  pixel_backlog[$];     // pixels waiting for the driver
    cab_out_t expected_writes[$];   // screen writes still owed by the block

    int pixels_queued = 0;
    int pixels_taken  = 0;
    int error_count   = 0;
    bit in_fire_q     = 1'b0;       // pixel beat taken at the last rising edge
    bit out_fire_q    = 1'b0;       // screen write taken at the last rising edge
    bit burst_mode    = 1'b0;       // no idling on either side while set
    int pix_gap       = 0;
    int rdy_gap       = 0;

    // where the pixel lands and what color it leaves; returns 1 when on screen
    function automatic bit paint_pixel(input cab_in_t px, output cab_out_t wr);
        int          sx;
        int          sy;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [31:0] mix;
        logic [15:0] shade;
        sx    = int'(cur_origin_x) + col_pos;
        sy    = int'(cur_origin_y) + row_pos;
        shade = px.pixel_color;
        if (cur_blend) begin
            // green goes to the upper half so all three channels get headroom
            fg  = ({16'h0, px.pixel_color} | {px.pixel_color, 16'h0}) & SPREAD_MASK;
            bg  = ({16'h0, cur_background} | {cur_background, 16'h0}) & SPREAD_MASK;
            // alpha rounded to 0..32, difference wraps in 32 bits
            mix = ((((fg - bg) * (({24'h0, px.alpha_value} + 32'd4) >> 3)) >> 5) + bg)
                  & SPREAD_MASK;
            shade = mix[15:0] | mix[31:16];
        end
        wr.screen_x  = sx[7:0];
        wr.screen_y  = sy[6:0];
        wr.out_color = shade;
        return (sx >= 0) && (sx < SCREEN_WIDTH) && (sy >= 0) && (sy < SCREEN_HEIGHT);
    endfunction

    // idle cycles before the next beat on either side
    function automatic int draw_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic flag_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_beats
        cab_out_t wr;
        cab_out_t want;
        if (!aresetn) begin
            in_fire_q  <= 1'b0;
            out_fire_q <= 1'b0;
            col_pos    = 0;
            row_pos    = 0;
        end else begin
            in_fire_q  <= s_valid && s_ready;
            out_fire_q <= m_valid && m_ready;

            // screen write beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected screen write, expected none, actual %0h",
                             $time, m_data);
                end else begin
                    want = expected_writes.pop_front();
                    flag_field("screen_x", want.screen_x, m_data.screen_x);
                    flag_field("screen_y", want.screen_y, m_data.screen_y);
                    flag_field("out_color", want.out_color, m_data.out_color);
                end
            end

            // pixel beat: predict, then step the raster counters
            if (s_valid && s_ready) begin
                pixels_taken++;
                if (paint_pixel(s_data, wr))
                    expected_writes.push_back(wr);
                // a counter past a shrunken size wraps, and a size of zero acts as one
                col_pos = (col_pos + 1) & 32'h7FFF;
                if (col_pos >= cur_width || col_pos == 0) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & 32'h7FFF;
                    if (row_pos >= cur_height || row_pos == 0)
                        row_pos = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel driver: one beat at a time from the backlog, random gaps
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            pix_gap <= draw_gap();
        end else if (!s_valid || in_fire_q) begin
            if (pix_gap != 0 || pixel_backlog.size() == 0) begin
                s_valid <= 1'b0;
                if (pix_gap != 0)
                    pix_gap <= pix_gap - 1;
            end else begin
                s_valid <= 1'b1;
                s_data  <= pixel_backlog.pop_front();
                pix_gap <= draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // screen side: ready drops for a random stall after each write beat
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_gap <= draw_gap();
        end else if (!m_ready || out_fire_q) begin
            if (rdy_gap != 0) begin
                m_ready <= 1'b0;
                rdy_gap <= rdy_gap - 1;
            end else begin
                m_ready <= 1'b1;
                rdy_gap <= draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // writes all six registers, one per clock; unused wdata bits carry junk
    task automatic load_setup(input int ox, input int oy, input int w, input int h,
                              input int bg, input bit blend);
        logic [2:0]  reg_ids[6];
        logic [15:0] reg_vals[6];
        reg_ids  = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT,
                     CFG_BACKGROUND, CFG_BLEND_ENABLE};
        reg_vals = '{ox[15:0], oy[15:0], {1'($urandom), w[14:0]}, {1'($urandom), h[14:0]},
                     bg[15:0], {15'($urandom), blend}};
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_wdata <= reg_vals[i];
        end
        @(negedge aclk);
        cfg_we         <= 1'b0;
        cur_origin_x   = ox[15:0];
        cur_origin_y   = oy[15:0];
        cur_width      = w[14:0];
        cur_height     = h[14:0];
        cur_background = bg[15:0];
        cur_blend      = blend;
    endtask

    task automatic queue_pixel(input logic [15:0] color, input logic [7:0] alpha);
        cab_in_t px;
        px.pixel_color = color;
        px.alpha_value = alpha;
        pixel_backlog.push_back(px);
        pixels_queued++;
    endtask

    // block idle: every pixel taken, every write seen, then drain off-screen pixels
    task automatic settle();
        while (pixels_taken != pixels_queued || expected_writes.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int          corner_x[4];
        int          corner_y[4];
        int          random_pixels;
        int          w;
        int          h;
        int          ox;
        int          oy;
        int          n;
        logic [7:0]  alpha;
        corner_x = '{-32768, 32767, 0, 159};
        corner_y = '{-32768, 32767, 0, 79};
        random_pixels = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero sizes act as 1x1: every pixel hits (0,0); white background
        // makes the blend difference wrap; alpha rounding edges
        load_setup(0, 0, 0, 0, 16'hFFFF, 1'b1);
        queue_pixel(16'h0000, 8'h00);
        queue_pixel(16'hFFFF, 8'hFF);
        queue_pixel(16'hFFFF, 8'h03);
        queue_pixel(16'hF81F, 8'h04);
        queue_pixel(16'h07E0, 8'hFB);
        queue_pixel(16'h0000, 8'hFC);
        settle();

        // 3x3 image over the bottom-right corner: right and bottom crop,
        // raw copy, last pixel takes both counters home
        load_setup(158, 78, 3, 3, 16'h1234, 1'b0);
        for (int i = 0; i < 9; i++)
            queue_pixel(16'($urandom), 8'($urandom));
        settle();

        // origin at the extremes: everything off screen, counters still move
        load_setup(-32768, 32767, 5, 4, 16'h0000, 1'b1);
        queue_pixel(16'hFFFF, 8'hFF);
        queue_pixel(16'h0000, 8'h00);
        settle();

        // negative origin_x mid-row: the counters carry on from the last image, so both pixels land at x 0 and 1
        load_setup(-2, 0, 5, 4, 16'h07E0, 1'b1);
        queue_pixel(16'hF800, 8'h80);
        queue_pixel(16'h001F, 8'h7F);
        settle();

        // image shrinks mid-row: column already past the new width wraps
        load_setup(150, 70, 2, 2, 16'hFFFF, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_pixel(16'($urandom), 8'($urandom));
        settle();

        // random images, mostly on screen, a few at the register extremes
        while (random_pixels < 1400) begin
            if ($urandom_range(0, 9) == 0) begin
                ox = corner_x[$urandom_range(0, 3)];
                oy = corner_y[$urandom_range(0, 3)];
                w  = $urandom_range(0, 1) ? 32767 : 1;
                h  = $urandom_range(0, 1) ? 32767 : 1;
                n  = $urandom_range(1, 40);
            end else begin
                w  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 24));
                h  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 12));
                ox = int'($urandom_range(0, 160 + w)) - w;
                oy = int'($urandom_range(0, 80 + h)) - h;
                // whole images mostly, partial ones leave the counters mid-image
                if ($urandom_range(0, 2) == 0 || w == 0 || h == 0)
                    n = $urandom_range(1, 60);
                else
                    n = w * h;
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            load_setup(ox, oy, w, h, int'($urandom_range(0, 65535)),
                       ($urandom_range(0, 3) != 0));
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0:       alpha = 8'h00;
                    1:       alpha = 8'hFF;
                    default: alpha = 8'($urandom);
                endcase
                queue_pixel(16'($urandom), alpha);
            end
            random_pixels += n;
            settle();
        end

        repeat (10) @(negedge aclk);
        if (error_count == 0 && expected_writes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cab_pkg.sv
rtl/cab_front.sv
rtl/cab_queue.sv
rtl/cab_back.sv
rtl/cropped_alpha_blit.sv
dv/cropped_alpha_blit_tb.sv
